// ===== hw/rtl/scti_pkg.sv =====
// Shared types, constants and ROM helper for the sine/cosine table interpolator.
`default_nettype none

package scti_pkg;

  // Item field widths
  localparam int ANGLE_W     = 20;
  localparam int SAMPLE_W    = 16;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;

  // Width of one angle magnitude (covers the cosine's shifted angle too)
  localparam int MAG_W = 20;

  // Table samples span -32768..+32768 and need one bit more than a sample
  localparam int ROM_W = SAMPLE_W + 1;

  // Register stages of one lane, input stage to output register
  localparam int NUM_STAGES = 9;

  // Fixed-point constants
  localparam int              INV_W          = 30;
  localparam logic [INV_W-1:0] INV_TWO_PI_Q32 = 30'd683565276;
  localparam logic [16:0]     HALF_PI_Q16    = 17'd102944;
  localparam logic [63:0]     HALF_PI_Q30    = 64'd1686629713;

  // Position bits below the binary point of mag * N / 2pi product
  localparam int POS_SHIFT = 48;

  // Stage enables and valid flags shared by the lanes
  typedef struct packed {
    logic [NUM_STAGES-1:0] en;
    logic [NUM_STAGES-1:0] valid;
  } scti_ctrl_t;

  // Quarter-wave sine magnitude, round(32768 * sin(x / 2^30)), by Taylor series
  function automatic logic [ROM_W-1:0] quarter_sine(input logic [63:0] x);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        t;
    logic signed [63:0] sum;
    logic [63:0]        scaled;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    for (int k = 1; k <= 9; k++) begin
      t = (term * x2) >> 30;
      case (k)
        1:       term = t / 6;
        2:       term = t / 20;
        3:       term = t / 42;
        4:       term = t / 72;
        5:       term = t / 110;
        6:       term = t / 156;
        7:       term = t / 210;
        8:       term = t / 272;
        default: term = t / 342;
      endcase
      if (k % 2 == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    scaled = ($unsigned(sum) * 64'd32768 + 64'd536870912) >> 30;
    return ROM_W'(scaled);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/scti_lane.sv =====
// One sine evaluation lane: magnitude, scaling, table lookup, interpolation, sign.
`default_nettype none

module scti_lane import scti_pkg::*; #(
  parameter int TABLE_ENTRIES = 1024,
  parameter int FRACTION_BITS = 12
) (
  input  wire logic                        clk_i,
  input  wire scti_ctrl_t                  ctrl_i,
  input  wire logic signed [ANGLE_W:0]     angle_i,
  output logic        signed [SAMPLE_W-1:0] result_o
);

  localparam int P1_W    = MAG_W + INV_W;
  localparam int P2_W    = P1_W + $clog2(TABLE_ENTRIES + 1);
  localparam int IR_W    = P2_W - POS_SHIFT;
  localparam int IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int ADDR_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int DIFF_W  = ROM_W + 1;
  localparam int PROD_W  = DIFF_W + FRACTION_BITS + 1;
  localparam int INT_W   = ROM_W + 2;

  localparam logic [IR_W-1:0]          N_WRAP   = IR_W'(TABLE_ENTRIES);
  localparam logic signed [PROD_W:0]   RND_HALF = (PROD_W + 1)'(1) <<< (FRACTION_BITS - 1);
  localparam logic signed [INT_W-1:0]  SAT_MAX  = INT_W'(32767);
  localparam logic signed [INT_W-1:0]  SAT_MIN  = -INT_W'(32768);
  localparam logic signed [INT_W-1:0]  PLUS_ONE = INT_W'(32768);
  localparam logic signed [DIFF_W-1:0] STEP_MAX = DIFF_W'((32768 * 7) / TABLE_ENTRIES + 2);

  // Sample k of one full sine period, built by quarter-wave symmetry
  function automatic logic signed [ROM_W-1:0] rom_entry(input int unsigned k);
    logic [63:0]      q4;
    logic [63:0]      q;
    logic [63:0]      rem;
    logic [63:0]      u;
    logic [63:0]      x;
    logic [ROM_W-1:0] v;
    q4  = 64'(k) * 64'd4;
    q   = q4 / TABLE_ENTRIES;
    rem = q4 % TABLE_ENTRIES;
    u   = q[0] ? 64'(TABLE_ENTRIES) - rem : rem;
    x   = (HALF_PI_Q30 * u) / TABLE_ENTRIES;
    v   = quarter_sine(x);
    return $signed(q[1] ? ROM_W'(0) - v : v);
  endfunction

  // Sine table, one period plus the closing entry
  logic signed [ROM_W-1:0] rom [TABLE_ENTRIES+1];

  for (genvar k = 0; k <= TABLE_ENTRIES; k++) begin : g_rom
    localparam logic signed [ROM_W-1:0] ENTRY_VAL = rom_entry(k);
    assign rom[k] = ENTRY_VAL;
  end

  logic [ANGLE_W:0]               mag_full;
  logic [MAG_W-1:0]               mag_q;
  logic [P1_W-1:0]                p1_q;
  logic [P2_W-1:0]                p2_q;
  logic [IR_W-1:0]                pos_int;
  logic [IDX_W-1:0]               idx_d, idx_q;
  logic [ADDR_W-1:0]              addr_lo, addr_hi;
  logic [FRACTION_BITS-1:0]       frac3_q, frac4_q, frac5_q;
  logic signed [ROM_W-1:0]        lo_q, hi_q, lo5_q, lo6_q;
  logic signed [DIFF_W-1:0]       diff_q;
  logic signed [PROD_W-1:0]       prod_q;
  logic signed [PROD_W:0]         rnd;
  logic signed [PROD_W:0]         rnd_sh;
  logic signed [INT_W-1:0]        interp_q;
  logic signed [INT_W-1:0]        signed_val;
  logic signed [SAMPLE_W-1:0]     result_d, result_q;
  logic [NUM_STAGES-2:0]          neg_q;

  // Split the angle into sign and magnitude
  assign mag_full = angle_i[ANGLE_W] ? (ANGLE_W + 1)'(-angle_i) : angle_i;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[0]) begin
      mag_q    <= mag_full[MAG_W-1:0];
    end
  end

  // Carry the sign of each item along the stages
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[0]) begin
      neg_q[0] <= angle_i[ANGLE_W];
    end
    for (int k = 1; k < NUM_STAGES - 1; k++) begin
      if (ctrl_i.en[k]) begin
        neg_q[k] <= neg_q[k-1];
      end
    end
  end

  // Scale by 1/2pi
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[1]) begin
      p1_q     <= P1_W'(mag_q) * P1_W'(INV_TWO_PI_Q32);
    end
  end

  // Scale by the table size
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[2]) begin
      p2_q     <= P2_W'(p1_q) * P2_W'(TABLE_ENTRIES);
    end
  end

  // Wrap the integer position into one period and take the fraction
  assign pos_int = p2_q[P2_W-1:POS_SHIFT];
  assign idx_d   = (pos_int >= N_WRAP) ? IDX_W'(pos_int - N_WRAP) : IDX_W'(pos_int);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[3]) begin
      idx_q    <= idx_d;
      frac3_q  <= p2_q[POS_SHIFT-FRACTION_BITS +: FRACTION_BITS];
    end
  end

  // Read both neighbors from the table
  assign addr_lo = ADDR_W'(idx_q);
  assign addr_hi = ADDR_W'(idx_q) + ADDR_W'(1);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[4]) begin
      lo_q     <= rom[addr_lo];
      hi_q     <= rom[addr_hi];
      frac4_q  <= frac3_q;
    end
  end

  // Form the slope between neighbors
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[5]) begin
      diff_q   <= DIFF_W'(hi_q) - DIFF_W'(lo_q);
      lo5_q    <= lo_q;
      frac5_q  <= frac4_q;
    end
  end

  // Weight the slope by the fraction
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[6]) begin
      prod_q   <= PROD_W'(diff_q) *
                  $signed({{(PROD_W - FRACTION_BITS){1'b0}}, frac5_q});
      lo6_q    <= lo5_q;
    end
  end

  // Round half up and add the lower neighbor
  assign rnd    = $signed((PROD_W + 1)'(prod_q)) + RND_HALF;
  assign rnd_sh = rnd >>> FRACTION_BITS;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[7]) begin
      interp_q <= INT_W'(lo6_q) + INT_W'(rnd_sh);
    end
  end

  // Apply the sign and saturate to the sample range
  assign signed_val = neg_q[7] ? -interp_q : interp_q;

  always_comb begin
    if (signed_val > SAT_MAX) begin
      result_d = SAMPLE_W'(SAT_MAX);
    end else if (signed_val < SAT_MIN) begin
      result_d = SAMPLE_W'(SAT_MIN);
    end else begin
      result_d = SAMPLE_W'(signed_val);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[8]) begin
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

`ifndef NO_ASSERTIONS
  // Wrapped index stays inside one period
  assert property (@(posedge clk_i)
    ctrl_i.valid[3] |-> ({1'b0, idx_q} < (IDX_W + 1)'(TABLE_ENTRIES)))
    else $error("table index not wrapped");

  // Neighbor samples lie within plus or minus one
  assert property (@(posedge clk_i)
    ctrl_i.valid[4] |-> (INT_W'(lo_q) <= PLUS_ONE) && (INT_W'(lo_q) >= -PLUS_ONE)
                        && (INT_W'(hi_q) <= PLUS_ONE) && (INT_W'(hi_q) >= -PLUS_ONE))
    else $error("table sample out of range");

  // Adjacent samples differ by no more than one table step of a sine
  assert property (@(posedge clk_i)
    ctrl_i.valid[5] |-> (diff_q <= STEP_MAX) && (diff_q >= -STEP_MAX))
    else $error("table neighbors too far apart");

  // Interpolated value stays within plus or minus one
  assert property (@(posedge clk_i)
    ctrl_i.valid[7] |-> (interp_q <= PLUS_ONE) && (interp_q >= -PLUS_ONE))
    else $error("interpolated value out of range");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/sine_cosine_table_interpolator_core.sv =====
// Top level of the sine/cosine table interpolator: stream ports and pipeline control.
//
// Takes a signed Q4.16 angle in radians and returns its sine and cosine in Q1.15,
// with +1.0 saturated to 32767. The angle magnitude is scaled by TABLE_ENTRIES/2pi;
// the integer part, wrapped into one period, picks two neighboring samples of a
// sine table and the fraction (FRACTION_BITS wide) interpolates between them, with
// the result negated for negative angles. The cosine runs the same path on the
// angle plus pi/2. Two identical 9-stage lanes work side by side, so one item is
// taken every clock unless an output stall fills the pipeline; each lane reads its
// table of TABLE_ENTRIES+1 constant samples through two synchronous ports in stage
// five. Every stage holds a valid flag and advances on its own when the stage after
// it is empty or moving, so bubbles close up under output stalls and input is
// refused only when all 9 stages hold items and the output is not taken.
`default_nettype none

module sine_cosine_table_interpolator_core import scti_pkg::*; #(
  parameter int TABLE_ENTRIES = 1024,
  parameter int FRACTION_BITS = 12
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,   // [19:0] angle
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  output logic      [OUT_TDATA_W-1:0] m_axis_tdata_o    // [15:0] sine_value, [31:16] cosine_value
);

  logic [NUM_STAGES-1:0]        v_q;
  logic [NUM_STAGES-1:0]        en;
  scti_ctrl_t                   ctrl;
  logic signed [ANGLE_W-1:0]    angle;
  logic signed [ANGLE_W:0]      sin_angle;
  logic signed [ANGLE_W:0]      cos_angle;
  logic signed [SAMPLE_W-1:0]   sine_value;
  logic signed [SAMPLE_W-1:0]   cosine_value;

  // Advance a stage when it is empty or the stage after it advances
  always_comb begin
    en[NUM_STAGES-1] = !v_q[NUM_STAGES-1] || m_axis_tready_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  // Move valid flags along with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= s_axis_tvalid_i;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign ctrl.en    = en;
  assign ctrl.valid = v_q;

  // Form the sine and cosine angles
  assign angle     = $signed(s_axis_tdata_i[ANGLE_W-1:0]);
  assign sin_angle = (ANGLE_W + 1)'(angle);
  assign cos_angle = (ANGLE_W + 1)'(angle) + $signed((ANGLE_W + 1)'(HALF_PI_Q16));

  scti_lane #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_sine_lane (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .angle_i  (sin_angle),
    .result_o (sine_value)
  );

  scti_lane #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_cosine_lane (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .angle_i  (cos_angle),
    .result_o (cosine_value)
  );

  assign s_axis_tready_o = en[0];
  assign m_axis_tvalid_o = v_q[NUM_STAGES-1];
  assign m_axis_tdata_o  = {cosine_value, sine_value};

`ifndef NO_ASSERTIONS
  // Input is refused only when every stage is full and the output stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (&v_q) && !m_axis_tready_i)
    else $error("input stalled with room in the pipeline");

  // An accepted item occupies the first stage next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> v_q[0])
    else $error("accepted item lost at pipeline entry");

  // A result appears only from an item in the stage before the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(v_q[NUM_STAGES-2]))
    else $error("result appeared without an item behind it");
`endif

endmodule

`default_nettype wire
